/* sv/srt_pkg.sv */
// ============================================================================
// srt_pkg: shared types and constants for the shadow ray triangle test
// Widths, register codes, micro-operation codes and the micro-program table.
// ============================================================================
`default_nettype none

package srt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int BIAS_W          = 13;
    localparam int EPS_W           = 49;
    localparam int LIMIT_W         = 32;
    localparam int FRAC_BITS       = 16;

    localparam logic [BIAS_W-1:0] BIAS_RESET = 13'd66;
    localparam logic [EPS_W-1:0]  EPS_RESET  = 49'd281474977;

    localparam logic REG_SHADOW_BIAS = 1'b0;
    localparam logic REG_DET_EPSILON = 1'b1;

    // Micro-program indexes that the sequencer branches on.
    localparam logic [4:0] OP_LAST_DOT = 5'd23;
    localparam logic [4:0] OP_BIAS     = 5'd24;
    localparam logic [4:0] OP_LIM      = 5'd25;

    typedef enum logic [3:0] {
        M_D0, M_D1, M_D2,
        M_E1_0, M_E1_1, M_E1_2,
        M_E2_0, M_E2_1, M_E2_2,
        M_TV0, M_TV1, M_TV2,
        M_BIAS, M_LIM
    } msel_t;

    typedef enum logic [3:0] {
        B_E1_0, B_E1_1, B_E1_2,
        B_E2_0, B_E2_1, B_E2_2,
        B_P0, B_P1, B_P2,
        B_Q0, B_Q1, B_Q2,
        B_DET
    } bsel_t;

    typedef enum logic [3:0] {
        D_NONE,
        D_P0, D_P1, D_P2,
        D_Q0, D_Q1, D_Q2,
        D_DET, D_UN, D_VN, D_TN
    } dest_t;

    typedef struct packed {
        msel_t msel;
        bsel_t bsel;
        logic  sub;
        logic  first;
        dest_t dest;
    } uop_t;

    typedef struct packed {
        logic start;
        logic clr;
        logic sub;
    } mac_ctrl_t;

    function automatic uop_t uop_at(input logic [4:0] idx);
        uop_t u;
        u = '{M_D0, B_E1_0, 1'b0, 1'b1, D_NONE};
        unique case (idx)
            5'd0:  u = '{M_D1,   B_E2_2, 1'b0, 1'b1, D_NONE};
            5'd1:  u = '{M_D2,   B_E2_1, 1'b1, 1'b0, D_P0};
            5'd2:  u = '{M_D2,   B_E2_0, 1'b0, 1'b1, D_NONE};
            5'd3:  u = '{M_D0,   B_E2_2, 1'b1, 1'b0, D_P1};
            5'd4:  u = '{M_D0,   B_E2_1, 1'b0, 1'b1, D_NONE};
            5'd5:  u = '{M_D1,   B_E2_0, 1'b1, 1'b0, D_P2};
            5'd6:  u = '{M_TV1,  B_E1_2, 1'b0, 1'b1, D_NONE};
            5'd7:  u = '{M_TV2,  B_E1_1, 1'b1, 1'b0, D_Q0};
            5'd8:  u = '{M_TV2,  B_E1_0, 1'b0, 1'b1, D_NONE};
            5'd9:  u = '{M_TV0,  B_E1_2, 1'b1, 1'b0, D_Q1};
            5'd10: u = '{M_TV0,  B_E1_1, 1'b0, 1'b1, D_NONE};
            5'd11: u = '{M_TV1,  B_E1_0, 1'b1, 1'b0, D_Q2};
            5'd12: u = '{M_E1_0, B_P0,   1'b0, 1'b1, D_NONE};
            5'd13: u = '{M_E1_1, B_P1,   1'b0, 1'b0, D_NONE};
            5'd14: u = '{M_E1_2, B_P2,   1'b0, 1'b0, D_DET};
            5'd15: u = '{M_TV0,  B_P0,   1'b0, 1'b1, D_NONE};
            5'd16: u = '{M_TV1,  B_P1,   1'b0, 1'b0, D_NONE};
            5'd17: u = '{M_TV2,  B_P2,   1'b0, 1'b0, D_UN};
            5'd18: u = '{M_D0,   B_Q0,   1'b0, 1'b1, D_NONE};
            5'd19: u = '{M_D1,   B_Q1,   1'b0, 1'b0, D_NONE};
            5'd20: u = '{M_D2,   B_Q2,   1'b0, 1'b0, D_VN};
            5'd21: u = '{M_E2_0, B_Q0,   1'b0, 1'b1, D_NONE};
            5'd22: u = '{M_E2_1, B_Q1,   1'b0, 1'b0, D_NONE};
            5'd23: u = '{M_E2_2, B_Q2,   1'b0, 1'b0, D_TN};
            5'd24: u = '{M_BIAS, B_DET,  1'b0, 1'b1, D_NONE};
            5'd25: u = '{M_LIM,  B_DET,  1'b0, 1'b1, D_NONE};
            default: u = '{M_D0, B_E1_0, 1'b0, 1'b1, D_NONE};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

/* sv/srt_mac.sv */
// ============================================================================
// srt_mac: bit-serial signed multiply-accumulate unit
// Adds or subtracts m*b into a wide accumulator, one multiplier bit a cycle.
// ============================================================================
`default_nettype none

module srt_mac
    import srt_pkg::*;
#(
    parameter int MW = 33,
    parameter int AW = 136
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  mac_ctrl_t            ctrl,
    input  wire signed [MW-1:0]  m,
    input  wire signed [AW-1:0]  b,
    output logic signed [AW-1:0] acc,
    output logic                 done
);

    localparam int CW = $clog2(MW);

    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] sh_reg;
    logic [MW-1:0]        mul_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 sub_reg;

    logic                 last_bit;
    logic                 eff_sub;
    logic signed [AW-1:0] addend;

    // The top multiplier bit carries negative weight, so it flips add and subtract.
    assign last_bit = (cnt_reg == CW'(MW - 1));
    assign eff_sub  = sub_reg ^ last_bit;
    assign addend   = mul_reg[0] ? sh_reg : '0;
    assign done     = busy_reg && last_bit;
    assign acc      = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            sh_reg   <= '0;
            mul_reg  <= '0;
            sub_reg  <= 1'b0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            sh_reg   <= b;
            mul_reg  <= m;
            sub_reg  <= ctrl.sub;
            if (ctrl.clr)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            acc_reg <= eff_sub ? (acc_reg - addend) : (acc_reg + addend);
            sh_reg  <= sh_reg <<< 1;
            mul_reg <= mul_reg >> 1;
            cnt_reg <= cnt_reg + 1'b1;
            if (last_bit)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/shadow_ray_triangle_test.sv */
// ============================================================================
// shadow_ray_triangle_test: exact fixed-point shadow-ray any-hit test
// Ray load with biased origin, then Moller-Trumbore tests on one shared MAC.
// ============================================================================
// A load word (cmd 0) sets the ray: the origin is the position pushed along
// the normal by shadow_bias (product floored, sum saturated), and a negative
// max_distance means no limit. A test word (cmd 1) checks one triangle against
// the stored ray with exact rational compares, no division and no rounding,
// and every word returns one result word with hit and the sticky occluded
// flag. All products of a test word run through a single bit-serial
// multiply-accumulate unit with a multiplier MW = max(COORD_WIDTH+1, 33) bits
// wide, under a micro-program of 26 operations; the load word's product uses
// a separate multiplier. The block takes one word at a time; a finished result
// waits in the output register while the next word is accepted.
`default_nettype none

module shadow_ray_triangle_test
    import srt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          cmd,
    input  wire signed [COORD_WIDTH-1:0] vec_a_x,
    input  wire signed [COORD_WIDTH-1:0] vec_a_y,
    input  wire signed [COORD_WIDTH-1:0] vec_a_z,
    input  wire signed [COORD_WIDTH-1:0] vec_b_x,
    input  wire signed [COORD_WIDTH-1:0] vec_b_y,
    input  wire signed [COORD_WIDTH-1:0] vec_b_z,
    input  wire signed [COORD_WIDTH-1:0] vec_c_x,
    input  wire signed [COORD_WIDTH-1:0] vec_c_y,
    input  wire signed [COORD_WIDTH-1:0] vec_c_z,
    input  wire signed [LIMIT_W-1:0]     max_distance,
    input  wire                          skip,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic                         hit,
    output logic                         occluded,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire                          cfg_index,
    input  wire [EPS_W-1:0]              cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int EW = W + 1;
    localparam int MW = (EW > LIMIT_W + 1) ? EW : LIMIT_W + 1;
    localparam int AW = 3 * W + 40;
    localparam int SW = W + BIAS_W + 2;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MAC_GO, S_MAC_WAIT, S_MAC_WB,
        S_NORM, S_CHK_EPS, S_CHK_U, S_CHK_UV,
        S_FIN_BIAS, S_FIN_LIM, S_DONE
    } state_t;

    state_t state_reg;

    // Configuration and ray state.
    logic [BIAS_W-1:0]    bias_reg;
    logic [EPS_W-1:0]     eps_reg;
    logic signed [W-1:0]  org_reg [3];
    logic signed [W-1:0]  dir_reg [3];
    logic signed [LIMIT_W-1:0] lim_reg;
    logic                 occ_reg;

    // Per-word working registers. During a load, tv holds the position and
    // e1 the normal.
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] tv_reg [3];
    logic signed [AW-1:0] p_reg [3];
    logic signed [AW-1:0] q_reg [3];
    logic signed [AW-1:0] det_reg;
    logic signed [AW-1:0] un_reg;
    logic signed [AW-1:0] vn_reg;
    logic signed [AW-1:0] tn_reg;

    logic [4:0]           op_reg;
    logic [1:0]           ld_idx_reg;
    logic                 ok_reg;
    logic                 res_hit_reg;

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic                 out_occ_reg;

    logic signed [W-1:0]  a_in [3];
    logic signed [W-1:0]  b_in [3];
    logic signed [W-1:0]  c_in [3];

    uop_t                 uop;
    mac_ctrl_t            mac_ctrl;
    logic signed [MW-1:0] mac_m;
    logic signed [AW-1:0] mac_b;
    logic signed [AW-1:0] mac_acc;
    logic                 mac_done;

    logic signed [SW-1:0] ld_prod;
    logic signed [SW-1:0] ld_sum;
    logic signed [SW-1:0] ld_sat;
    logic signed [AW-1:0] tn_sh;
    logic signed [AW-1:0] eps_ext;
    logic signed [AW-1:0] uv_sum;
    logic                 lim_hit;

    assign a_in = '{vec_a_x, vec_a_y, vec_a_z};
    assign b_in = '{vec_b_x, vec_b_y, vec_b_z};
    assign c_in = '{vec_c_x, vec_c_y, vec_c_z};

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign occluded  = out_occ_reg;

    // Origin offset: floor(normal * bias / 2^16) added to the position, clamped.
    assign ld_prod = SW'(e1_reg[ld_idx_reg]) * SW'(signed'({1'b0, bias_reg}));
    assign ld_sum  = SW'(tv_reg[ld_idx_reg]) + (ld_prod >>> FRAC_BITS);
    assign ld_sat  = (ld_sum > SAT_HI) ? SAT_HI : ((ld_sum < SAT_LO) ? SAT_LO : ld_sum);

    assign tn_sh   = tn_reg <<< FRAC_BITS;
    assign eps_ext = AW'(signed'({1'b0, eps_reg}));
    assign uv_sum  = un_reg + vn_reg;
    assign lim_hit = lim_reg[LIMIT_W-1] || (tn_sh < mac_acc);

    assign uop            = uop_at(op_reg);
    assign mac_ctrl.start = (state_reg == S_MAC_GO);
    assign mac_ctrl.clr   = uop.first;
    assign mac_ctrl.sub   = uop.sub;

    always_comb
    begin
        unique case (uop.msel)
            M_D0:    mac_m = MW'(dir_reg[0]);
            M_D1:    mac_m = MW'(dir_reg[1]);
            M_D2:    mac_m = MW'(dir_reg[2]);
            M_E1_0:  mac_m = MW'(e1_reg[0]);
            M_E1_1:  mac_m = MW'(e1_reg[1]);
            M_E1_2:  mac_m = MW'(e1_reg[2]);
            M_E2_0:  mac_m = MW'(e2_reg[0]);
            M_E2_1:  mac_m = MW'(e2_reg[1]);
            M_E2_2:  mac_m = MW'(e2_reg[2]);
            M_TV0:   mac_m = MW'(tv_reg[0]);
            M_TV1:   mac_m = MW'(tv_reg[1]);
            M_TV2:   mac_m = MW'(tv_reg[2]);
            M_BIAS:  mac_m = MW'(signed'({1'b0, bias_reg}));
            M_LIM:   mac_m = MW'(lim_reg);
            default: mac_m = '0;
        endcase
    end

    always_comb
    begin
        unique case (uop.bsel)
            B_E1_0:  mac_b = AW'(e1_reg[0]);
            B_E1_1:  mac_b = AW'(e1_reg[1]);
            B_E1_2:  mac_b = AW'(e1_reg[2]);
            B_E2_0:  mac_b = AW'(e2_reg[0]);
            B_E2_1:  mac_b = AW'(e2_reg[1]);
            B_E2_2:  mac_b = AW'(e2_reg[2]);
            B_P0:    mac_b = p_reg[0];
            B_P1:    mac_b = p_reg[1];
            B_P2:    mac_b = p_reg[2];
            B_Q0:    mac_b = q_reg[0];
            B_Q1:    mac_b = q_reg[1];
            B_Q2:    mac_b = q_reg[2];
            B_DET:   mac_b = det_reg;
            default: mac_b = '0;
        endcase
    end

    srt_mac #(
        .MW (MW),
        .AW (AW)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .m     (mac_m),
        .b     (mac_b),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bias_reg      <= BIAS_RESET;
            eps_reg       <= EPS_RESET;
            org_reg       <= '{default: '0};
            dir_reg       <= '{default: '0};
            lim_reg       <= '0;
            occ_reg       <= 1'b0;
            e1_reg        <= '{default: '0};
            e2_reg        <= '{default: '0};
            tv_reg        <= '{default: '0};
            p_reg         <= '{default: '0};
            q_reg         <= '{default: '0};
            det_reg       <= '0;
            un_reg        <= '0;
            vn_reg        <= '0;
            tn_reg        <= '0;
            op_reg        <= '0;
            ld_idx_reg    <= '0;
            ok_reg        <= 1'b0;
            res_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_occ_reg   <= 1'b0;
        end
        else
        begin
            // In the done state the result register is refilled below instead.
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SHADOW_BIAS: bias_reg <= cfg_data[BIAS_W-1:0];
                    REG_DET_EPSILON: eps_reg  <= cfg_data;
                    default:         eps_reg  <= eps_reg;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (!cmd)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                tv_reg[i]  <= EW'(a_in[i]);
                                e1_reg[i]  <= EW'(b_in[i]);
                                dir_reg[i] <= c_in[i];
                            end
                            lim_reg    <= max_distance;
                            ld_idx_reg <= '0;
                            state_reg  <= S_LOAD;
                        end
                        else if (skip)
                        begin
                            res_hit_reg <= 1'b0;
                            state_reg   <= S_DONE;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                e1_reg[i] <= EW'(b_in[i]) - EW'(a_in[i]);
                                e2_reg[i] <= EW'(c_in[i]) - EW'(a_in[i]);
                                tv_reg[i] <= EW'(org_reg[i]) - EW'(a_in[i]);
                            end
                            op_reg    <= '0;
                            state_reg <= S_MAC_GO;
                        end
                    end
                end

                S_LOAD:
                begin
                    org_reg[ld_idx_reg] <= ld_sat[W-1:0];
                    if (ld_idx_reg == 2'd2)
                    begin
                        occ_reg     <= 1'b0;
                        res_hit_reg <= 1'b0;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        ld_idx_reg <= ld_idx_reg + 2'd1;
                    end
                end

                S_MAC_GO:
                begin
                    state_reg <= S_MAC_WAIT;
                end

                S_MAC_WAIT:
                begin
                    if (mac_done)
                    begin
                        state_reg <= S_MAC_WB;
                    end
                end

                S_MAC_WB:
                begin
                    unique case (uop.dest)
                        D_P0:    p_reg[0] <= mac_acc;
                        D_P1:    p_reg[1] <= mac_acc;
                        D_P2:    p_reg[2] <= mac_acc;
                        D_Q0:    q_reg[0] <= mac_acc;
                        D_Q1:    q_reg[1] <= mac_acc;
                        D_Q2:    q_reg[2] <= mac_acc;
                        D_DET:   det_reg  <= mac_acc;
                        D_UN:    un_reg   <= mac_acc;
                        D_VN:    vn_reg   <= mac_acc;
                        D_TN:    tn_reg   <= mac_acc;
                        default: det_reg  <= det_reg;
                    endcase
                    priority if (op_reg == OP_LAST_DOT)
                    begin
                        state_reg <= S_NORM;
                    end
                    else if (op_reg == OP_BIAS)
                    begin
                        state_reg <= S_FIN_BIAS;
                    end
                    else if (op_reg == OP_LIM)
                    begin
                        state_reg <= S_FIN_LIM;
                    end
                    else
                    begin
                        op_reg    <= op_reg + 5'd1;
                        state_reg <= S_MAC_GO;
                    end
                end

                S_NORM:
                begin
                    // Fold the sign of the determinant into all numerators.
                    if (det_reg < 0)
                    begin
                        det_reg <= -det_reg;
                        un_reg  <= -un_reg;
                        vn_reg  <= -vn_reg;
                        tn_reg  <= -tn_reg;
                    end
                    ok_reg    <= (det_reg != '0);
                    state_reg <= S_CHK_EPS;
                end

                S_CHK_EPS:
                begin
                    ok_reg    <= ok_reg && (det_reg >= eps_ext) && (un_reg >= 0) && (vn_reg >= 0);
                    state_reg <= S_CHK_U;
                end

                S_CHK_U:
                begin
                    ok_reg    <= ok_reg && (un_reg <= det_reg);
                    state_reg <= S_CHK_UV;
                end

                S_CHK_UV:
                begin
                    ok_reg    <= ok_reg && (uv_sum <= det_reg);
                    op_reg    <= OP_BIAS;
                    state_reg <= S_MAC_GO;
                end

                S_FIN_BIAS:
                begin
                    ok_reg    <= ok_reg && (tn_sh > mac_acc);
                    op_reg    <= OP_LIM;
                    state_reg <= S_MAC_GO;
                end

                S_FIN_LIM:
                begin
                    res_hit_reg <= ok_reg && lim_hit;
                    if (ok_reg && lim_hit)
                    begin
                        occ_reg <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        hit_reg       <= res_hit_reg;
                        out_occ_reg   <= occ_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/srt_checker.sv */
// ============================================================================
// srt_checker: port-level checks for the shadow ray triangle test
// Watches the handshakes and result words and is bound to the top level.
// ============================================================================
`default_nettype none

module srt_checker
(
    input wire clk,
    input wire rst_n,
    input wire in_valid,
    input wire in_ready,
    input wire out_valid,
    input wire out_ready,
    input wire hit,
    input wire occluded
);

    // A hit always sets the sticky flag in the same result word.
    a_hit_sets_occluded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!hit || occluded))
        else $error("hit reported without occluded");

    // The block works on one word at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after accepting a word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(hit) && $stable(occluded)))
        else $error("result word changed while stalled");

endmodule

bind shadow_ray_triangle_test srt_checker u_srt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .occluded  (occluded)
);

`default_nettype wire

/* dv/tb_shadow_ray_triangle_test.sv */
// ============================================================================
// tb_shadow_ray_triangle_test: self-checking bench for the shadow ray test
// Directed and random ray loads and triangle tests. Each accepted word goes
// through an exact wide-integer model of the any-hit test. Every result word
// is checked against the oldest prediction, across several register settings.
// ============================================================================
`default_nettype none

module tb_shadow_ray_triangle_test
    import srt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = COORD_WIDTH_DEF;
    localparam int CYCLE_CAP  = 6000000;
    localparam int TAIL_WAIT  = 1200;
    localparam int RANDOM_CNT = 380;

    localparam bit CMD_LOAD = 1'b0;
    localparam bit CMD_TEST = 1'b1;

    // Products in the hit test reach about 135 bits, so 192 leaves headroom.
    typedef logic signed [191:0] wide_t;

    typedef struct {
        bit                 cmd;
        logic signed [31:0] a[3];
        logic signed [31:0] b[3];
        logic signed [31:0] c[3];
        logic signed [31:0] lim;
        bit                 skip;
    } word_t;

    typedef struct {
        bit hit;
        bit occ;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 cmd = 1'b0;
    logic signed [CW-1:0] vec_a_x = '0, vec_a_y = '0, vec_a_z = '0;
    logic signed [CW-1:0] vec_b_x = '0, vec_b_y = '0, vec_b_z = '0;
    logic signed [CW-1:0] vec_c_x = '0, vec_c_y = '0, vec_c_z = '0;
    logic signed [31:0]   max_distance = '0;
    logic                 skip = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 hit;
    logic                 occluded;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = REG_SHADOW_BIAS;
    logic [EPS_W-1:0]     cfg_data = '0;

    // Model of the block: ray registers, sticky flag and configuration.
    longint          ray_org[3];
    longint          ray_dir[3];
    longint          ray_lim;
    bit              ray_occ;
    longint          bias_val;
    logic [EPS_W-1:0] eps_val;

    verdict_t pending_verdicts[$];
    int       fail_count = 0;
    int       cycle_count = 0;
    bit       calm = 1'b0;

    shadow_ray_triangle_test dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .vec_a_x(vec_a_x), .vec_a_y(vec_a_y), .vec_a_z(vec_a_z),
        .vec_b_x(vec_b_x), .vec_b_y(vec_b_y), .vec_b_z(vec_b_z),
        .vec_c_x(vec_c_x), .vec_c_y(vec_c_y), .vec_c_z(vec_c_z),
        .max_distance(max_distance), .skip(skip),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .occluded(occluded),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // The run is bounded by a cycle counter.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("FAIL shadow_ray_triangle_test");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    // Three-component cross product in wide integers.
    function automatic void cross_wide(input longint x[3], input longint y[3],
                                       output wide_t r[3]);
        wide_t x0, x1, x2, y0, y1, y2;
        x0 = wide_t'(x[0]); x1 = wide_t'(x[1]); x2 = wide_t'(x[2]);
        y0 = wide_t'(y[0]); y1 = wide_t'(y[1]); y2 = wide_t'(y[2]);
        r[0] = x1 * y2 - x2 * y1;
        r[1] = x2 * y0 - x0 * y2;
        r[2] = x0 * y1 - x1 * y0;
    endfunction

    function automatic wide_t dot_wide(input longint x[3], input wide_t y[3]);
        wide_t x0, x1, x2;
        x0 = wide_t'(x[0]); x1 = wide_t'(x[1]); x2 = wide_t'(x[2]);
        return x0 * y[0] + x1 * y[1] + x2 * y[2];
    endfunction

    // Exact any-hit test of one triangle against the stored ray.
    function automatic bit triangle_blocks_ray(input word_t w);
        longint e1[3], e2[3], tv[3];
        wide_t  p[3], q[3];
        wide_t  det, un, vn, tn, eps_w, bias_w, lim_w, scaled;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = longint'(w.b[i]) - longint'(w.a[i]);
            e2[i] = longint'(w.c[i]) - longint'(w.a[i]);
            tv[i] = ray_org[i] - longint'(w.a[i]);
        end
        cross_wide(ray_dir, e2, p);
        det = dot_wide(e1, p);
        if (det == 0)
            return 1'b0;
        cross_wide(tv, e1, q);
        un = dot_wide(tv, p);
        vn = dot_wide(ray_dir, q);
        tn = dot_wide(e2, q);
        if (det < 0)
        begin
            det = -det;
            un = -un;
            vn = -vn;
            tn = -tn;
        end
        eps_w = {143'b0, eps_val};
        bias_w = wide_t'(bias_val);
        lim_w = wide_t'(ray_lim);
        scaled = tn * 65536;
        if (det < eps_w)
            return 1'b0;
        if (un < 0 || un > det)
            return 1'b0;
        if (vn < 0 || un + vn > det)
            return 1'b0;
        if (scaled <= det * bias_w)
            return 1'b0;
        if (ray_lim >= 0 && scaled >= det * lim_w)
            return 1'b0;
        return 1'b1;
    endfunction

    // Advances the model by one accepted word and returns its result word.
    function automatic verdict_t predict_word(input word_t w);
        verdict_t v;
        longint   hi, lo, s;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        v.hit = 1'b0;
        if (w.cmd == CMD_LOAD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // Arithmetic shift of the product gives the floor directly.
                s = longint'(w.a[i]) + ((longint'(w.b[i]) * bias_val) >>> 16);
                if (s > hi)
                    s = hi;
                if (s < lo)
                    s = lo;
                ray_org[i] = s;
                ray_dir[i] = longint'(w.c[i]);
            end
            ray_lim = longint'(w.lim);
            ray_occ = 1'b0;
        end
        else if (!w.skip)
        begin
            v.hit = triangle_blocks_ray(w);
            if (v.hit)
                ray_occ = 1'b1;
        end
        v.occ = ray_occ;
        return v;
    endfunction

    // Sends one word, with a random gap before it unless the bench is calm.
    // The gap lowers valid before the word is driven; otherwise valid stays high.
    task automatic send_word(input word_t w);
        verdict_t v;
        if (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= w.cmd;
        vec_a_x <= w.a[0]; vec_a_y <= w.a[1]; vec_a_z <= w.a[2];
        vec_b_x <= w.b[0]; vec_b_y <= w.b[1]; vec_b_z <= w.b[2];
        vec_c_x <= w.c[0]; vec_c_y <= w.c[1]; vec_c_z <= w.c[2];
        max_distance <= w.lim;
        skip <= w.skip;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        v = predict_word(w);
        pending_verdicts.insert(pending_verdicts.size(), v);
    endtask

    // Lowers valid and waits until every result word has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Register writes happen only with the block drained.
    task automatic write_register(input logic idx, input logic [EPS_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_SHADOW_BIAS)
            bias_val = longint'(value[BIAS_W-1:0]);
        else
            eps_val = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic word_t noise_word();
        word_t w;
        w.cmd = 1'($urandom_range(1));
        for (int i = 0; i < 3; i++)
        begin
            w.a[i] = $urandom;
            w.b[i] = $urandom;
            w.c[i] = $urandom;
        end
        w.lim = $urandom;
        w.skip = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic longint rand_span(input int mag);
        return longint'($urandom_range(2 * mag)) - mag;
    endfunction

    function automatic word_t ray_word(input longint lim);
        word_t w;
        w.cmd = CMD_LOAD;
        w.skip = 1'($urandom_range(1));
        for (int i = 0; i < 3; i++)
        begin
            w.a[i] = 32'(rand_span(1 << 24));
            w.b[i] = 32'(rand_span(1 << 17));
            w.c[i] = 32'(rand_span(1 << 17));
        end
        w.lim = 32'(lim);
        return w;
    endfunction

    // Triangle scattered around the point at k ray lengths along the stored ray,
    // so a good share of these really block the ray.
    function automatic word_t aimed_triangle(input int k, input int spread);
        word_t  w;
        longint ctr;
        w.cmd = CMD_TEST;
        w.skip = 1'b0;
        w.lim = $urandom;
        for (int i = 0; i < 3; i++)
        begin
            ctr = ray_org[i] + ray_dir[i] * k;
            w.a[i] = 32'(ctr + rand_span(spread));
            w.b[i] = 32'(ctr + rand_span(spread));
            w.c[i] = 32'(ctr + rand_span(spread));
        end
        return w;
    endfunction

    // Extremes of each field, saturation, degenerate and skipped triangles,
    // and the limit cases.
    task automatic test_directed();
        word_t w;
        w = noise_word();
        w.cmd = CMD_TEST;
        w.skip = 1'b0;
        send_word(w);                       // test against whatever ray is stored
        w = ray_word(-1);
        w.a = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
        w.b = '{32'sh7fffffff, 32'sh00000000, 32'sh80000000};
        send_word(w);                       // saturation both ways
        w = aimed_triangle(1, 1 << 16);
        send_word(w);
        w = ray_word(-1);
        w.a = '{32'sh80000000, 32'sh7fffffff, 32'sh00000000};
        w.b = '{32'sh80000000, 32'sh7fffffff, 32'sh00000001};
        w.c = '{32'sh7fffffff, 32'sh80000000, 32'shffffffff};
        send_word(w);
        w = ray_word(32'sh7fffffff);
        w.c = '{32'sh00000000, 32'sh00000000, 32'sh00010000};
        send_word(w);
        w = aimed_triangle(4, 0);           // all vertices equal: zero determinant
        send_word(w);
        for (int i = 0; i < 4; i++)
            send_word(aimed_triangle(4, 1 << 20));
        w = aimed_triangle(4, 1 << 20);
        w.skip = 1'b1;
        send_word(w);                       // skipped triangle
        w = aimed_triangle(-3, 1 << 20);
        send_word(w);                       // behind the origin
        send_word(ray_word(0));             // zero limit blocks nothing
        for (int i = 0; i < 3; i++)
            send_word(aimed_triangle(2, 1 << 20));
        send_word(ray_word(32'sh80000000)); // most negative limit: unlimited
        for (int i = 0; i < 3; i++)
            send_word(aimed_triangle(30, 1 << 20));
        w = noise_word();
        w.cmd = CMD_LOAD;
        w.lim = 32'sh00000001;
        send_word(w);
        drain_results();
    endtask

    // Mostly well-formed scenes: one load and a run of aimed triangles.
    task automatic test_random_scenes(input int count);
        int     sent;
        int     k;
        longint lim;
        sent = 0;
        while (sent < count)
        begin
            calm = (sent > count / 3) && (sent < count / 2);
            k = $urandom_range(1, 40);
            case ($urandom_range(3))
                0: lim = -longint'($urandom_range(1, 1000));
                1: lim = longint'($urandom_range(0, 32'h7fffffff));
                default: lim = longint'(k) * 65536 + rand_span(k * 65536);
            endcase
            if (lim > 64'sh7fffffff)
                lim = 64'sh7fffffff;
            send_word(ray_word(lim));
            sent++;
            repeat ($urandom_range(2, 8))
            begin
                if ($urandom_range(9) == 0)
                    send_word(noise_word());
                else
                    send_word(aimed_triangle($urandom_range(1, 40),
                                             1 << $urandom_range(12, 22)));
                sent++;
            end
        end
        calm = 1'b0;
        drain_results();
    endtask

    task automatic test_noise(input int count);
        for (int i = 0; i < count; i++)
            send_word(noise_word());
        drain_results();
    endtask

    // Receiver stalls at random, except in the calm stretch.
    always @(posedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 23);
    end

    // Each result word is compared with the oldest prediction.
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                exp_v = pending_verdicts.pop_front();
                if (hit !== exp_v.hit)
                    report_mismatch($sformatf("hit %b, expected %b", hit, exp_v.hit));
                if (occluded !== exp_v.occ)
                    report_mismatch($sformatf("occluded %b, expected %b",
                                              occluded, exp_v.occ));
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            ray_org[i] = 0;
            ray_dir[i] = 0;
        end
        ray_lim = 0;
        ray_occ = 1'b0;
        bias_val = longint'(BIAS_RESET);
        eps_val = EPS_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_scenes(RANDOM_CNT / 5);
        write_register(REG_SHADOW_BIAS, 49'd6554);
        write_register(REG_DET_EPSILON, 49'd0);
        test_directed();
        test_random_scenes(RANDOM_CNT / 5);
        write_register(REG_SHADOW_BIAS, 49'd1);
        write_register(REG_DET_EPSILON, 49'h1000000000000);
        test_random_scenes(RANDOM_CNT / 10);
        write_register(REG_SHADOW_BIAS, 49'd0);
        write_register(REG_DET_EPSILON, 49'({$urandom, $urandom} & 49'hffffffffff));
        test_random_scenes(RANDOM_CNT / 5);
        test_noise(RANDOM_CNT / 10);
        write_register(REG_SHADOW_BIAS, 49'h1fff);
        write_register(REG_DET_EPSILON, 49'h1ffffffffffff);
        test_noise(RANDOM_CNT / 20);
        write_register(REG_SHADOW_BIAS, 49'($urandom_range(1, 6554)));
        write_register(REG_DET_EPSILON, 49'($urandom_range(0, 32'h7fffffff)));
        test_random_scenes(RANDOM_CNT / 5);

        repeat (TAIL_WAIT) @(posedge clk);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("PASS shadow_ray_triangle_test");
        else
            $display("FAIL shadow_ray_triangle_test");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/srt_pkg.sv
sv/srt_mac.sv
sv/shadow_ray_triangle_test.sv
sv/srt_checker.sv
dv/tb_shadow_ray_triangle_test.sv
